@@ rtl/fpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-step phase decode package
// Shared types, constants and the arctangent table of the phase decoder.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int GREY_W       = 8;
    localparam int PERIOD_W     = 11;
    localparam int OUT_W        = 19;
    localparam int ANG_BITS     = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int PRESCALE     = 16;

    // CORDIC datapath: samples of up to 8 bits scaled by 2^16, gain and
    // quadrant fold included, fit in 27 signed bits.
    localparam int CW           = 27;
    localparam int ZW           = ANG_BITS + 1;
    localparam int ATAN_W       = 22;

    localparam int PROD_W       = ANG_BITS + PERIOD_W;
    localparam int TRUNC_W      = PROD_W - (ANG_BITS - FRAC_BITS);
    localparam int POS_W        = TRUNC_W + 1;
    localparam int EXT_W        = (POS_W > OUT_W) ? POS_W : OUT_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16);

    // Fixed cycles from an accepted word to its result strobe.
    localparam int LATENCY      = CORDIC_STEPS + 5;

    // atan(2^-i) as a fraction of one turn, scaled by 2^24.
    localparam logic [ATAN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81
    };

    // One classified pixel: the cosine folded into the right half plane.
    typedef struct packed {
        logic [GREY_W-1:0]        x;
        logic signed [GREY_W:0]   y;
        logic                     half_turn;
    } fpd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fpd_q_status_t;

endpackage

@@ rtl/fpd_front.sv @@
// ----------------------------------------------------------------------------
// Phase decode front end
// Accepts a pixel word, forms the sine and cosine differences and folds the
// vector into the right half plane before handing it to the queue.
// ----------------------------------------------------------------------------
module fpd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fpd_pkg::GREY_W-1:0]   grey0,
    input  logic [fpd_pkg::GREY_W-1:0]   grey1,
    input  logic [fpd_pkg::GREY_W-1:0]   grey2,
    input  logic [fpd_pkg::GREY_W-1:0]   grey3,
    input  fpd_pkg::fpd_q_status_t       q_status,
    output logic                         push,
    output fpd_pkg::fpd_item_t           push_item
);
    import fpd_pkg::*;

    logic                    vld_reg;
    logic                    vld_next;
    logic                    load;
    logic signed [GREY_W:0]  sine;
    logic signed [GREY_W:0]  cosine;
    logic signed [GREY_W:0]  neg_cos;
    fpd_item_t               item_reg;
    fpd_item_t               item_next;

    assign busy = vld_reg && q_status.full;
    assign push = vld_reg && !q_status.full;
    assign load = start && !busy;

    always_comb
    begin
        sine    = $signed({1'b0, grey0}) - $signed({1'b0, grey2});
        cosine  = $signed({1'b0, grey1}) - $signed({1'b0, grey3});
        neg_cos = -cosine;
        // A vector in the left half plane is turned by half a turn.
        if (cosine[GREY_W])
        begin
            item_next.x         = neg_cos[GREY_W-1:0];
            item_next.y         = -sine;
            item_next.half_turn = 1'b1;
        end
        else
        begin
            item_next.x         = cosine[GREY_W-1:0];
            item_next.y         = sine;
            item_next.half_turn = 1'b0;
        end
    end

    always_comb
    begin
        if (load)
            vld_next = 1'b1;
        else if (push)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign push_item = item_reg;

endmodule

@@ rtl/fpd_queue.sv @@
// ----------------------------------------------------------------------------
// Phase decode queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fpd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fpd_pkg::fpd_item_t      push_item,
    input  logic                    pop,
    output fpd_pkg::fpd_item_t      pop_item,
    output fpd_pkg::fpd_q_status_t  q_status
);
    import fpd_pkg::*;

    fpd_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_item       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/fpd_back.sv @@
// ----------------------------------------------------------------------------
// Phase decode back end
// Pipelined vectoring CORDIC giving the angle as a fraction of a turn,
// followed by the scaling to the fringe period and the wrap into one period.
// ----------------------------------------------------------------------------
module fpd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    input  fpd_pkg::fpd_item_t             in_item,
    input  logic [fpd_pkg::PERIOD_W-1:0]   period,
    output logic                           done,
    output logic [fpd_pkg::OUT_W-1:0]      phase_position
);
    import fpd_pkg::*;

    logic                   vld_reg  [CORDIC_STEPS+1];
    logic signed [CW-1:0]   x_reg    [CORDIC_STEPS+1];
    logic signed [CW-1:0]   y_reg    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   z_reg    [CORDIC_STEPS+1];
    logic                   half_reg [CORDIC_STEPS+1];

    logic                   mul_vld_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ANG_BITS-1:0]    angle;
    logic [TRUNC_W-1:0]     scaled;
    logic [POS_W-1:0]       pos;
    logic [POS_W-1:0]       full_scale;
    logic [POS_W-1:0]       pos_wrap;
    logic [EXT_W-1:0]       pos_ext;
    logic                   out_vld_reg;
    logic [OUT_W-1:0]       out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            x_reg[0]    <= $signed({{(CW-GREY_W-PRESCALE){1'b0}}, in_item.x, {PRESCALE{1'b0}}});
            y_reg[0]    <= $signed({{(CW-GREY_W-1-PRESCALE){in_item.y[GREY_W]}}, in_item.y,
                                    {PRESCALE{1'b0}}});
            z_reg[0]    <= '0;
            half_reg[0] <= in_item.half_turn;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] step_ang;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        assign dx       = y_reg[k] >>> k;
        assign dy       = x_reg[k] >>> k;
        assign step_ang = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_TURN[k]});

        always_comb
        begin
            x_next = x_reg[k];
            y_next = y_reg[k];
            z_next = z_reg[k];
            // Once the vector lies on the axis the remaining steps do nothing.
            if (y_reg[k] != '0)
            begin
                if (!y_reg[k][CW-1])
                begin
                    x_next = x_reg[k] + dx;
                    y_next = y_reg[k] - dy;
                    z_next = z_reg[k] + step_ang;
                end
                else
                begin
                    x_next = x_reg[k] - dx;
                    y_next = y_reg[k] + dy;
                    z_next = z_reg[k] - step_ang;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            x_reg[k+1]    <= x_next;
            y_reg[k+1]    <= y_next;
            z_reg[k+1]    <= z_next;
            half_reg[k+1] <= half_reg[k];
        end
    end

    // The angle wraps modulo one turn.
    assign angle = z_reg[CORDIC_STEPS][ANG_BITS-1:0]
                   + {half_reg[CORDIC_STEPS], {(ANG_BITS-1){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= vld_reg[CORDIC_STEPS];
            out_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(angle) * PROD_W'(period);
    end

    always_comb
    begin
        scaled     = prod_reg[PROD_W-1:ANG_BITS-FRAC_BITS];
        pos        = POS_W'(scaled) + (POS_W'(1) << (FRAC_BITS - 1));
        full_scale = POS_W'({period, {FRAC_BITS{1'b0}}});
        pos_wrap   = (pos > full_scale) ? pos - full_scale : pos;
        pos_ext    = EXT_W'(pos_wrap);
    end

    always_ff @(posedge clk)
    begin
        out_reg <= pos_ext[OUT_W-1:0];
    end

    assign done           = out_vld_reg;
    assign phase_position = out_reg;

endmodule

@@ rtl/four_step_phase_decode.sv @@
// ----------------------------------------------------------------------------
// Four-step phase decode
// Decodes one pixel of a four-step phase-shifted fringe sequence into its
// position within the fringe period.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock cycle: a word is taken at every
// edge where start is high and busy is low. Each result appears on
// phase_position for exactly one cycle with done high, and results come
// out in the order the words went in. A word passes through the front
// end's input register, the queue, the back end's input register, the
// 16-stage CORDIC pipeline, the multiply stage and the output register.
// The result is always taken at once, so the back end never stalls, the
// queue never fills, and busy stays low in normal use. Users must write
// fringe_period only while no pixel is in flight; nothing enforces it.
module four_step_phase_decode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fpd_pkg::GREY_W-1:0]     grey0,
    input  logic [fpd_pkg::GREY_W-1:0]     grey1,
    input  logic [fpd_pkg::GREY_W-1:0]     grey2,
    input  logic [fpd_pkg::GREY_W-1:0]     grey3,
    input  logic                           cfg_wr_en,
    input  logic [fpd_pkg::PERIOD_W-1:0]   cfg_wr_data,
    output logic                           done,
    output logic [fpd_pkg::OUT_W-1:0]      phase_position
);
    import fpd_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    fpd_q_status_t       q_status;
    logic                push;
    fpd_item_t           push_item;
    logic                pop;
    fpd_item_t           pop_item;

    assign period_next = cfg_wr_en ? cfg_wr_data : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else
            period_reg <= period_next;
    end

    // The back end takes a word whenever one is waiting.
    assign pop = !q_status.empty;

    fpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .grey0     (grey0),
        .grey1     (grey1),
        .grey2     (grey2),
        .grey3     (grey3),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    fpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    fpd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_vld         (pop),
        .in_item        (pop_item),
        .period         (period_reg),
        .done           (done),
        .phase_position (phase_position)
    );

endmodule

@@ rtl/fpd_checker.sv @@
// ----------------------------------------------------------------------------
// Phase decode port checker
// Checks the timing and range of results seen at the decoder's ports.
// ----------------------------------------------------------------------------
module fpd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        done,
    input  logic [fpd_pkg::OUT_W-1:0]   phase_position
);
    import fpd_pkg::*;

    // Every word taken gives its result a fixed number of cycles later.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && rst_n) |-> ##LATENCY done)
        else $error("result strobe missing after a taken word");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching word");

    // The half-pixel offset keeps every result above zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (phase_position != '0))
        else $error("result of zero");

    // The back end never stalls, so the front end is never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the back end never stalls");

endmodule

bind four_step_phase_decode fpd_checker u_fpd_checker (.*);

@@ tb/fpd_position_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-step phase decode checker
// Watches the pixel, configuration and result channels of the phase decoder.
// It predicts the decoded position of every accepted word and compares each
// result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module fpd_position_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [fpd_pkg::GREY_W-1:0]     grey0,
    input  logic [fpd_pkg::GREY_W-1:0]     grey1,
    input  logic [fpd_pkg::GREY_W-1:0]     grey2,
    input  logic [fpd_pkg::GREY_W-1:0]     grey3,
    input  logic                           cfg_wr_en,
    input  logic [fpd_pkg::PERIOD_W-1:0]   cfg_wr_data,
    input  logic                           done,
    input  logic [fpd_pkg::OUT_W-1:0]      phase_position,
    output int                             positions_in_flight,
    output int                             fail_count
);
    import fpd_pkg::*;

    localparam int N_STEPS = 16;

    // atan(2^-i) as a fraction of one turn, scaled by 2^24.
    localparam longint ARCTAN_TURN [N_STEPS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    logic [PERIOD_W-1:0] period_now;
    logic [OUT_W-1:0]    expected_positions [$];

    // Vectoring CORDIC on the two differences, then scaling to the period.
    function automatic logic [OUT_W-1:0] decoded_position(
        input logic [GREY_W-1:0]   g0,
        input logic [GREY_W-1:0]   g1,
        input logic [GREY_W-1:0]   g2,
        input logic [GREY_W-1:0]   g3,
        input logic [PERIOD_W-1:0] period
    );
        longint          sine;
        longint          cosine;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          base;
        longint unsigned angle;
        longint unsigned pos;
        longint unsigned full;
        sine   = longint'(g0) - longint'(g2);
        cosine = longint'(g1) - longint'(g3);
        angle  = 0;
        if (sine != 0 || cosine != 0)
        begin
            // Fold the left half plane over by half a turn.
            if (cosine < 0)
            begin
                x    = -cosine * 65536;
                y    = -sine * 65536;
                base = longint'(1) << (ANG_BITS - 1);
            end
            else
            begin
                x    = cosine * 65536;
                y    = sine * 65536;
                base = 0;
            end
            z = 0;
            for (int i = 0; i < N_STEPS && y != 0; i++)
            begin
                // Arithmetic shifts of signed values round toward minus infinity.
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_TURN[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_TURN[i];
                end
            end
            angle = longint'(base + z) & ((longint'(1) << ANG_BITS) - 1);
        end
        pos  = ((angle * longint'(period)) >> (ANG_BITS - FRAC_BITS))
               + (longint'(1) << (FRAC_BITS - 1));
        full = longint'(period) << FRAC_BITS;
        if (pos > full)
            pos = pos - full;
        return pos[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_now = PERIOD_W'(16);
            expected_positions.delete();
            positions_in_flight = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("phase_position: strobe with no word pending, actual %0d",
                           phase_position);
                    fail_count++;
                end
                else
                begin
                    if (phase_position !== expected_positions[0])
                    begin
                        $error("phase_position mismatch: expected %0d, actual %0d",
                               expected_positions[0], phase_position);
                        fail_count++;
                    end
                    void'(expected_positions.pop_front());
                end
            end
            if (cfg_wr_en)
                period_now = cfg_wr_data;
            if (start && !busy)
                expected_positions.push_back(
                    decoded_position(grey0, grey1, grey2, grey3, period_now));
            positions_in_flight = expected_positions.size();
        end
    end

endmodule

@@ tb/tb_four_step_phase_decode.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-step phase decode testbench
// Drives pixel words and fringe period settings into the phase decoder with
// random gaps, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_four_step_phase_decode;
    import fpd_pkg::*;

    localparam int MAX_CYCLES    = 400000;
    localparam int WORDS_PER_SET = 255;
    localparam int N_SETS        = 6;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [GREY_W-1:0]   grey0       = '0;
    logic [GREY_W-1:0]   grey1       = '0;
    logic [GREY_W-1:0]   grey2       = '0;
    logic [GREY_W-1:0]   grey3       = '0;
    logic                cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;
    logic                busy;
    logic                done;
    logic [OUT_W-1:0]    phase_position;
    int                  positions_in_flight;
    int                  fail_count;
    int unsigned         cycle_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    four_step_phase_decode i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .grey0          (grey0),
        .grey1          (grey1),
        .grey2          (grey2),
        .grey3          (grey3),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .phase_position (phase_position)
    );

    fpd_position_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .grey0               (grey0),
        .grey1               (grey1),
        .grey2               (grey2),
        .grey3               (grey3),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .done                (done),
        .phase_position      (phase_position),
        .positions_in_flight (positions_in_flight),
        .fail_count          (fail_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(10, 60);
    endfunction

    // Called at a rising edge; returns at the edge that took the word, or, when gap is nonzero, after the idle gap.
    task automatic send_word(
        input logic [GREY_W-1:0] g0,
        input logic [GREY_W-1:0] g1,
        input logic [GREY_W-1:0] g2,
        input logic [GREY_W-1:0] g3,
        input int                gap
    );
        start <= 1'b1;
        grey0 <= g0;
        grey1 <= g1;
        grey2 <= g2;
        grey3 <= g3;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_word(input bit burst);
        logic [GREY_W-1:0] g [4];
        int                kind;
        kind = $urandom_range(0, 9);
        foreach (g[i])
            g[i] = GREY_W'($urandom_range(0, 255));
        case (kind)
            0: g[2] = g[0];
            1: g[3] = g[1];
            2:
            begin
                // Flat pixel: no fringe contrast at all.
                g[2] = g[0];
                g[3] = g[1];
            end
            3:
            begin
                // Angle zero or just short of a full turn, close to the wrap point.
                g[2] = (g[0] > 250) ? 8'd255 : g[0] + GREY_W'($urandom_range(1, 4));
                g[1] = GREY_W'($urandom_range(128, 255));
                g[3] = GREY_W'($urandom_range(0, 64));
            end
            4:
            begin
                g[2] = g[0] ^ GREY_W'($urandom_range(0, 3));
                g[3] = g[1] ^ GREY_W'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_word(g[0], g[1], g[2], g[3], burst ? 0 : pick_gap());
    endtask

    // Returns at a rising edge once every predicted word has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (positions_in_flight != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [PERIOD_W-1:0] periods [N_SETS];
        bit                  burst;
        periods = '{11'd1024, 11'd1, 11'd0, 11'd2047,
                    PERIOD_W'($urandom_range(2, 1023)),
                    PERIOD_W'($urandom_range(0, 2047))};
        burst = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset period.
        send_word(8'd0,   8'd0,   8'd0,   8'd0,   pick_gap());  // no contrast
        send_word(8'd255, 8'd255, 8'd255, 8'd255, pick_gap());  // saturated, flat
        send_word(8'd0,   8'd255, 8'd0,   8'd0,   pick_gap());  // zero angle
        send_word(8'd255, 8'd0,   8'd0,   8'd0,   pick_gap());  // quarter turn
        send_word(8'd0,   8'd0,   8'd0,   8'd255, pick_gap());  // half turn
        send_word(8'd0,   8'd0,   8'd255, 8'd0,   pick_gap());  // three quarters
        send_word(8'd255, 8'd255, 8'd0,   8'd0,   pick_gap());
        send_word(8'd0,   8'd0,   8'd255, 8'd255, pick_gap());
        send_word(8'd255, 8'd0,   8'd0,   8'd255, pick_gap());
        send_word(8'd0,   8'd255, 8'd255, 8'd0,   pick_gap());
        send_word(8'd1,   8'd0,   8'd0,   8'd0,   pick_gap());
        send_word(8'd0,   8'd1,   8'd0,   8'd0,   pick_gap());
        send_word(8'd0,   8'd0,   8'd1,   8'd0,   pick_gap());
        send_word(8'd0,   8'd0,   8'd0,   8'd1,   pick_gap());
        send_word(8'd0,   8'd255, 8'd1,   8'd0,   pick_gap());  // wraps at period
        send_word(8'd128, 8'd127, 8'd127, 8'd128, pick_gap());
        send_word(8'd170, 8'd85,  8'd85,  8'd170, pick_gap());
        send_word(8'd85,  8'd170, 8'd170, 8'd85,  pick_gap());
        send_word(8'd254, 8'd1,   8'd255, 8'd0,   pick_gap());
        send_word(8'd1,   8'd254, 8'd0,   8'd255, 0);

        for (int s = 0; s < N_SETS; s++)
        begin
            start <= 1'b0;
            wait_drained();
            write_period(periods[s]);
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                // Runs of 32 words are sometimes sent with no gap at all.
                if (n % 32 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                random_word(burst);
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fpd_pkg.sv
rtl/fpd_front.sv
rtl/fpd_queue.sv
rtl/fpd_back.sv
rtl/four_step_phase_decode.sv
rtl/fpd_checker.sv
tb/fpd_position_checker.sv
tb/tb_four_step_phase_decode.sv
